[design/mlmc_pkg.sv]
// shared types and constants of the motion light mode controller
`timescale 1ns / 1ps

package mlmc_pkg;

    localparam int KIND_W     = 3;
    localparam int MODE_W     = 2;
    localparam int SEC_W      = 16;
    localparam int ELAPSED_W  = 27;
    localparam int THRESH_W   = 26;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPLY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INC    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEC    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_MOTION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

    localparam int MS_PER_SEC = 1000;
    localparam int HOLD_STEP  = 5;
    localparam int LIMIT_STEP = 10;

    localparam logic [SEC_W-1:0]     HOLD_RESET  = 16'd30;
    localparam logic [SEC_W-1:0]     LIMIT_RESET = 16'd3600;
    localparam logic [SEC_W-1:0]     SEC_MAX     = 16'hFFFF;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 27'h7FF_FFFF;

    localparam logic CFG_HOLD  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [SEC_W-1:0] hold_default;
        logic [SEC_W-1:0] on_limit_default;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              changed;
        logic              light;
    } t_result;

endpackage

[design/motion_light_mode_controller.sv]
// top level of the motion light mode controller: config registers, core and result queue
`timescale 1ns / 1ps

// Motion sensor light controller.
// Input stream: s_axis_tuser carries the request kind (tick, sensor sample,
// apply mode, increase timer, decrease timer); s_axis_tdata carries the
// motion bit and the mode selector. Every accepted request gives exactly one
// result on the output stream: light state, change flag and current mode.
// The state update happens at the accepting edge, where the result is also
// written into the result queue, which presents it on m_axis. Throughput is
// one request per cycle while s_axis_tready is high, set by the combinational
// compare-and-update of the core against its own state. Results wait in a
// two-entry queue, so input stays ready while one result waits; s_axis_tready
// drops whenever two results are stored. Configuration writes on i_cfg_* load
// the default hold and forced-on times, used at the next mode apply.
// Reset (synchronous, active low) turns the light off, selects motion mode,
// clears the millisecond counter, loads 30 s hold and 3600 s limit, and
// empties the queue.

module motion_light_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // motion [0], mode_select [2:1], zeros
    input  logic [2:0]  s_axis_tuser,   // kind [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // light [0], changed [1], mode [3:2], zeros
);

    mlmc_pkg::t_cfg     r_cfg;
    mlmc_pkg::t_result  core_result;
    mlmc_pkg::t_result  r_queue [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               push;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_default     <= mlmc_pkg::HOLD_RESET;
            r_cfg.on_limit_default <= mlmc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mlmc_pkg::CFG_HOLD:  r_cfg.hold_default     <= i_cfg_data;
                mlmc_pkg::CFG_LIMIT: r_cfg.on_limit_default <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign push = s_axis_tvalid & s_axis_tready;
    assign pop  = m_axis_tvalid & m_axis_tready;

    mlmc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (push),
        .i_kind        (s_axis_tuser),
        .i_motion      (s_axis_tdata[0]),
        .i_mode_select (s_axis_tdata[2:1]),
        .i_cfg         (r_cfg),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = {4'b0000, r_queue[r_rd_ptr].mode,
                            r_queue[r_rd_ptr].changed, r_queue[r_rd_ptr].light};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_count == 2'd0) |=> m_axis_tvalid)
        else $error("result missing after accepted request");

    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:2] != mlmc_pkg::MODE_RSVD))
        else $error("reserved mode on output");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue count wrong after drain");

endmodule

[design/mlmc_core.sv]
// light, mode, timer state and the combinational next-state update for one request
`timescale 1ns / 1ps

module mlmc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mlmc_pkg::KIND_W-1:0]   i_kind,
    input  logic                          i_motion,
    input  logic [mlmc_pkg::MODE_W-1:0]   i_mode_select,
    input  mlmc_pkg::t_cfg                i_cfg,
    output mlmc_pkg::t_result             o_result
);

    logic                               r_light;
    logic [mlmc_pkg::MODE_W-1:0]        r_mode;
    logic [mlmc_pkg::ELAPSED_W-1:0]     r_elapsed;
    logic [mlmc_pkg::SEC_W-1:0]         r_hold_sec;
    logic [mlmc_pkg::SEC_W-1:0]         r_limit_sec;

    logic                               n_light;
    logic [mlmc_pkg::MODE_W-1:0]        n_mode;
    logic [mlmc_pkg::ELAPSED_W-1:0]     n_elapsed;
    logic [mlmc_pkg::SEC_W-1:0]         n_hold_sec;
    logic [mlmc_pkg::SEC_W-1:0]         n_limit_sec;
    logic                               changed;

    logic [mlmc_pkg::THRESH_W-1:0]      hold_ms;
    logic [mlmc_pkg::THRESH_W-1:0]      limit_ms;
    logic                               hold_reached;
    logic                               limit_reached;
    logic [mlmc_pkg::SEC_W:0]           hold_sum;
    logic [mlmc_pkg::SEC_W:0]           limit_sum;
    logic [mlmc_pkg::SEC_W-1:0]         hold_dec;
    logic [mlmc_pkg::SEC_W-1:0]         limit_dec;

    assign hold_ms  = mlmc_pkg::THRESH_W'(r_hold_sec)
                    * mlmc_pkg::THRESH_W'(mlmc_pkg::MS_PER_SEC);
    assign limit_ms = mlmc_pkg::THRESH_W'(r_limit_sec)
                    * mlmc_pkg::THRESH_W'(mlmc_pkg::MS_PER_SEC);
    assign hold_reached  = r_elapsed >= {1'b0, hold_ms};
    assign limit_reached = r_elapsed >= {1'b0, limit_ms};

    // saturating timer steps
    assign hold_sum  = {1'b0, r_hold_sec} + (mlmc_pkg::SEC_W+1)'(mlmc_pkg::HOLD_STEP);
    assign limit_sum = {1'b0, r_limit_sec} + (mlmc_pkg::SEC_W+1)'(mlmc_pkg::LIMIT_STEP);
    assign hold_dec  = (r_hold_sec < mlmc_pkg::SEC_W'(mlmc_pkg::HOLD_STEP)) ? '0
                     : r_hold_sec - mlmc_pkg::SEC_W'(mlmc_pkg::HOLD_STEP);
    assign limit_dec = (r_limit_sec < mlmc_pkg::SEC_W'(mlmc_pkg::LIMIT_STEP)) ? '0
                     : r_limit_sec - mlmc_pkg::SEC_W'(mlmc_pkg::LIMIT_STEP);

    always_comb begin
        n_light     = r_light;
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_hold_sec  = r_hold_sec;
        n_limit_sec = r_limit_sec;
        changed     = 1'b0;
        unique case (i_kind)
            mlmc_pkg::KIND_TICK: begin
                if (r_elapsed != mlmc_pkg::ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            mlmc_pkg::KIND_SAMPLE: begin
                case (r_mode)
                    mlmc_pkg::MODE_MOTION: begin
                        if ((r_light != i_motion) && (i_motion || hold_reached)) begin
                            n_light   = i_motion;
                            n_elapsed = '0;
                            changed   = 1'b1;
                        end
                    end
                    mlmc_pkg::MODE_ON: begin
                        if (!r_light) begin
                            n_light   = 1'b1;
                            n_elapsed = '0;
                            changed   = 1'b1;
                        end else if (limit_reached) begin
                            n_mode = mlmc_pkg::MODE_MOTION;
                        end
                    end
                    mlmc_pkg::MODE_OFF: begin
                        if (r_light) begin
                            n_light = 1'b0;
                            changed = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mlmc_pkg::KIND_APPLY: begin
                if (i_mode_select != mlmc_pkg::MODE_RSVD) begin
                    n_mode      = i_mode_select;
                    n_hold_sec  = i_cfg.hold_default;
                    n_limit_sec = i_cfg.on_limit_default;
                    n_elapsed   = '0;
                end
            end
            mlmc_pkg::KIND_INC: begin
                if (r_mode == mlmc_pkg::MODE_MOTION) begin
                    n_hold_sec = hold_sum[mlmc_pkg::SEC_W] ? mlmc_pkg::SEC_MAX
                               : hold_sum[mlmc_pkg::SEC_W-1:0];
                end else if (r_mode == mlmc_pkg::MODE_ON) begin
                    n_limit_sec = limit_sum[mlmc_pkg::SEC_W] ? mlmc_pkg::SEC_MAX
                                : limit_sum[mlmc_pkg::SEC_W-1:0];
                end
            end
            mlmc_pkg::KIND_DEC: begin
                if (r_mode == mlmc_pkg::MODE_MOTION) begin
                    n_hold_sec = hold_dec;
                end else if (r_mode == mlmc_pkg::MODE_ON) begin
                    n_limit_sec = limit_dec;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.light   = n_light;
    assign o_result.changed = changed;
    assign o_result.mode    = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light     <= 1'b0;
            r_mode      <= mlmc_pkg::MODE_MOTION;
            r_elapsed   <= '0;
            r_hold_sec  <= mlmc_pkg::HOLD_RESET;
            r_limit_sec <= mlmc_pkg::LIMIT_RESET;
        end else if (i_valid) begin
            r_light     <= n_light;
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_hold_sec  <= n_hold_sec;
            r_limit_sec <= n_limit_sec;
        end
    end

endmodule
